@@ rtl/csv_field_reader_unit_macros.svh @@
// assertion macros for the csv field reader
`ifndef CSV_FIELD_READER_UNIT_MACROS_SVH
`define CSV_FIELD_READER_UNIT_MACROS_SVH

// same-cycle implication under reset
`define CSVFR_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("csv field reader check failed");

// next-cycle implication under reset
`define CSVFR_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("csv field reader check failed");

`endif

@@ rtl/csvfr_pkg.sv @@
// types and constants shared by the csv field reader
package csvfr_pkg;

    localparam logic [7:0]  CH_COMMA   = 8'h2C;
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

    // register indexes
    localparam logic CFG_MAX_LEN    = 1'b0;
    localparam logic CFG_DELIM_MODE = 1'b1;

    // delimiter modes
    localparam logic [1:0] MODE_COMMA   = 2'd0;
    localparam logic [1:0] MODE_LINE    = 2'd1;
    localparam logic [1:0] MODE_EITHER  = 2'd2;
    localparam logic [1:0] MODE_REPORT  = 2'd3;

    // end status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY_EOS  = 2'd1;
    localparam logic [1:0] ST_NO_COMMA   = 2'd2;
    localparam logic [1:0] ST_UNEXP_COMMA = 2'd3;

    // delimiter kinds
    localparam logic [1:0] DK_COMMA   = 2'd0;
    localparam logic [1:0] DK_NEWLINE = 2'd1;
    localparam logic [1:0] DK_EOS     = 2'd2;

    // result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_char;
        logic [1:0] status;
        logic [1:0] delim_kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic        quoting;
        logic        quote_pending;
        logic        discarding;
        logic [15:0] char_count;
    } field_state_t;

    localparam field_state_t FIELD_CLEAR = '{
        quoting: 1'b0, quote_pending: 1'b0, discarding: 1'b0, char_count: 16'd0
    };

endpackage

@@ rtl/csvfr_step.sv @@
// per-byte field parsing: next field state and the optional result
module csvfr_step
    import csvfr_pkg::*;
(
    input  field_state_t state,
    input  item_t        item,
    input  logic [15:0]  max_len,
    input  logic [1:0]   delim_mode,
    output field_state_t state_next,
    output logic         has_result,
    output result_t      result
);

    logic        quoting_now;
    logic        stop;
    logic        nat_end;
    logic [1:0]  nat_dk;
    logic [1:0]  nat_status;
    logic [15:0] count_inc;

    // status of a field ended by its own delimiter
    always_comb
    begin
        if (delim_mode == MODE_COMMA && nat_dk == DK_EOS && state.char_count == 16'd0)
            nat_status = ST_EMPTY_EOS;
        else if (delim_mode == MODE_COMMA && nat_dk != DK_COMMA)
            nat_status = ST_NO_COMMA;
        else if (delim_mode == MODE_LINE && nat_dk == DK_COMMA)
            nat_status = ST_UNEXP_COMMA;
        else
            nat_status = ST_OK;
    end

    assign count_inc = (state.char_count != COUNT_MAX) ? state.char_count + 16'd1
                                                       : state.char_count;

    always_comb
    begin
        state_next  = state;
        has_result  = 1'b0;
        result      = '0;
        quoting_now = state.quoting;
        nat_end     = 1'b0;
        nat_dk      = DK_COMMA;
        stop        = item.end_of_stream || item.in_byte == CH_NEWLINE ||
                      (delim_mode != MODE_LINE && item.in_byte == CH_COMMA);

        if (state.discarding)
        begin
            if (stop)
            begin
                has_result        = 1'b1;
                result.kind       = KIND_END;
                result.status     = ST_OK;
                result.delim_kind = (delim_mode == MODE_COMMA) ? DK_COMMA : DK_NEWLINE;
                result.last       = 1'b1;
                state_next        = FIELD_CLEAR;
            end
        end
        else if (state.quote_pending && !item.end_of_stream && item.in_byte == CH_QUOTE)
        begin
            // doubled quote
            state_next.quote_pending = 1'b0;
            has_result      = 1'b1;
            result.kind     = KIND_CHAR;
            result.out_char = CH_QUOTE;
        end
        else
        begin
            if (state.quote_pending)
            begin
                quoting_now = !state.quoting;
            end
            state_next.quote_pending = 1'b0;
            state_next.quoting       = quoting_now;

            if (item.end_of_stream)
            begin
                nat_end = 1'b1;
                nat_dk  = DK_EOS;
            end
            else if (item.in_byte == CH_NEWLINE)
            begin
                nat_end = 1'b1;
                nat_dk  = DK_NEWLINE;
            end
            else if (item.in_byte == CH_COMMA && !quoting_now)
            begin
                nat_end = 1'b1;
                nat_dk  = DK_COMMA;
            end

            if (nat_end)
            begin
                has_result        = 1'b1;
                result.kind       = KIND_END;
                result.status     = nat_status;
                result.delim_kind = nat_dk;
                result.last       = 1'b1;
                state_next        = FIELD_CLEAR;
            end
            else
            begin
                state_next.char_count = count_inc;
                if (count_inc >= max_len)
                begin
                    state_next.discarding = 1'b1;
                end
                else if (item.in_byte == CH_QUOTE)
                begin
                    state_next.quote_pending = 1'b1;
                end
                else
                begin
                    has_result      = 1'b1;
                    result.kind     = KIND_CHAR;
                    result.out_char = item.in_byte;
                end
            end
        end
    end

endmodule

@@ rtl/csv_field_reader_unit.sv @@
// csv field reader top level: input register, parse step, result register
// path: a byte's result, if any, goes from the input register through the parse step into the result register
// throughput: one byte per cycle, limited only by stalls on the result side
// the field state feeds back through one compare and increment for each parsed byte
// reset: field state clears, max_len returns to 256 and delim_mode to 0
module csv_field_reader_unit
    import csvfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic         hold_valid_reg;
    item_t        hold_item_reg;
    field_state_t state_reg;
    field_state_t state_next;
    logic         out_valid_reg;
    result_t      out_result_reg;
    logic [15:0]  max_len_reg;
    logic [1:0]   delim_mode_reg;

    logic         step_has;
    result_t      step_result;
    logic         out_free;
    logic         step_fire;

    csvfr_step u_step (
        .state      (state_reg),
        .item       (hold_item_reg),
        .max_len    (max_len_reg),
        .delim_mode (delim_mode_reg),
        .state_next (state_next),
        .has_result (step_has),
        .result     (step_result)
    );

    assign out_free   = !out_valid_reg || result_ready;
    assign step_fire  = hold_valid_reg && out_free;
    assign item_ready = !hold_valid_reg || out_free;
    assign cfg_ready  = 1'b1;

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= FIELD_CLEAR;
            max_len_reg    <= MAX_LEN_RESET;
            delim_mode_reg <= MODE_COMMA;
        end
        else
        begin
            if (item_ready)
            begin
                hold_valid_reg <= item_valid;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= step_fire && step_has;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MAX_LEN:    max_len_reg    <= cfg_data;
                    CFG_DELIM_MODE: delim_mode_reg <= cfg_data[1:0];
                    default:        max_len_reg    <= max_len_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            hold_item_reg <= item;
        end
        if (step_fire && step_has)
        begin
            out_result_reg <= step_result;
        end
    end

endmodule

@@ rtl/csvfr_checker.sv @@
// port-level checks for the csv field reader, bound to the top level
`include "csv_field_reader_unit_macros.svh"

module csvfr_checker
    import csvfr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result,
    input logic    cfg_valid,
    input logic    cfg_ready
);

    logic res_stall;
    logic end_shape;
    logic char_shape;
    logic shape_ok;

    assign res_stall  = result_valid && !result_ready;
    assign end_shape  = result.last && result.out_char == 8'd0 && result.delim_kind <= DK_EOS;
    assign char_shape = !result.last && result.status == ST_OK && result.delim_kind == DK_COMMA;
    assign shape_ok   = (result.kind == KIND_END) ? end_shape : char_shape;

    // a stalled result transfer keeps its payload
    `CSVFR_ASSERT_NEXT(a_result_hold, clk, rst_n, res_stall, result_valid && $stable(result))

    // with no pending result the input side never stalls
    `CSVFR_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !result_valid, item_ready)

    // field end results carry last and no character, data results carry no end info
    `CSVFR_ASSERT_NOW(a_result_shape, clk, rst_n, result_valid, shape_ok)

    // configuration writes are never held off
    `CSVFR_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind csv_field_reader_unit csvfr_checker u_csvfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
